// ===== hdl/kfs_pkg.sv =====
package kfs_pkg;

    localparam int DATA_W = 32;
    localparam int VAR_W  = 31;
    localparam int ADDR_W = 5;

    typedef logic signed [DATA_W-1:0] sdata_t;
    typedef logic [VAR_W-1:0]         var_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [2:0]               reg_idx_t;

    // register map, index = paddr / 4
    localparam reg_idx_t REG_TRANS   = 3'd0;
    localparam reg_idx_t REG_ACTION  = 3'd1;
    localparam reg_idx_t REG_PROCESS = 3'd2;
    localparam reg_idx_t REG_SENSOR  = 3'd3;
    localparam reg_idx_t REG_MEAS    = 3'd4;

endpackage

// ===== hdl/kfs_req_if.sv =====
interface kfs_req_if;

    logic               valid;
    logic               ready;
    kfs_pkg::sdata_t    action;
    kfs_pkg::sdata_t    measurement;

    modport source (output valid, output action, output measurement, input ready);
    modport sink (input valid, input action, input measurement, output ready);

endinterface

// ===== hdl/kfs_rsp_if.sv =====
interface kfs_rsp_if;

    logic               valid;
    logic               ready;
    kfs_pkg::sdata_t    estimate;
    kfs_pkg::var_t      variance;
    logic               fault;

    modport source (output valid, output estimate, output variance, output fault, input ready);
    modport sink (input valid, input estimate, input variance, input fault, output ready);

endinterface

// ===== hdl/scalar_kalman_filter_step_top.sv =====
// channel   dir   handshake      payload
// req       in    valid/ready    action, measurement
// rsp       out   valid/ready    estimate, variance, fault
// apb       in    psel/penable   paddr, pwdata, pwrite -> prdata, pready
//
// one request computes ten products on one shared 32x32
// multiplier (issue and accumulate for each) plus a restoring divider with a
// 34-bit quotient for the gain; a zero or negative denominator skips the divider
// reset clears estimate to 0, variance and all config registers to 1.0, no clearing pass
// req.ready is high only while idle; a finished response waits in the output
// register, and a new result is held back until that register is free
module scalar_kalman_filter_step_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    kfs_req_if.sink              req,
    kfs_rsp_if.source            rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  kfs_pkg::addr_t       paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIVI = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DIVF = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [3:0] STEP_AX = 4'd0;
    localparam logic [3:0] STEP_BU = 4'd1;
    localparam logic [3:0] STEP_AP = 4'd2;
    localparam logic [3:0] STEP_AT = 4'd3;
    localparam logic [3:0] STEP_HP = 4'd4;
    localparam logic [3:0] STEP_HG = 4'd5;
    localparam logic [3:0] STEP_HX = 4'd6;
    localparam logic [3:0] STEP_KE = 4'd7;
    localparam logic [3:0] STEP_KH = 4'd8;
    localparam logic [3:0] STEP_MP = 4'd9;

    localparam int         Q_W       = 34;
    localparam logic [5:0] DIV_STEPS = 6'(Q_W);

    localparam logic [31:0]        ONE_CFG = 32'd1 << FRAC_BITS;
    localparam logic signed [63:0] ONE64   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF64  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic [Q_W-1:0]     Q_HALF  = Q_W'(64'd1 << 31);

    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        sx64 = signed'({{32{v[31]}}, v});
    endfunction

    function automatic logic [32:0] sat32_f(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat32_f = {1'b1, 32'h7fff_ffff};
        else if (v < -64'sd2147483648)
            sat32_f = {1'b1, 32'h8000_0000};
        else
            sat32_f = {1'b0, v[31:0]};
    endfunction

    function automatic logic [31:0] sat31_f(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            sat31_f = {1'b1, 31'h7fff_ffff};
        else if (v < 64'sd0)
            sat31_f = {1'b1, 31'h0};
        else
            sat31_f = {1'b0, v[30:0]};
    endfunction

    // control
    logic [2:0]         state_reg;
    logic [3:0]         step_reg;
    logic [5:0]         cnt_reg;
    logic               out_valid_reg;

    // configuration and filter state
    kfs_pkg::sdata_t    trans_reg;
    kfs_pkg::sdata_t    action_gain_reg;
    kfs_pkg::var_t      process_reg;
    kfs_pkg::sdata_t    sensor_reg;
    kfs_pkg::var_t      meas_reg;
    kfs_pkg::sdata_t    est_reg;
    kfs_pkg::var_t      var_reg;

    // datapath
    kfs_pkg::sdata_t    u_reg;
    kfs_pkg::sdata_t    z_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    kfs_pkg::sdata_t    xp_reg;
    kfs_pkg::sdata_t    tmp_reg;
    kfs_pkg::var_t      pp_reg;
    kfs_pkg::sdata_t    k_reg;
    logic               tf_reg;
    logic               fault_reg;
    logic               ovf_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        dq_reg;
    kfs_pkg::sdata_t    out_est_reg;
    kfs_pkg::var_t      out_var_reg;
    logic               out_fault_reg;

    kfs_pkg::sdata_t    op_a;
    kfs_pkg::sdata_t    op_b;
    logic signed [63:0] rnd;
    logic signed [63:0] sum_s;
    logic signed [63:0] s32_in;
    logic signed [63:0] s31_in;
    logic [32:0]        s32_res;
    logic [31:0]        s31_res;
    logic signed [63:0] num;
    logic [63:0]        num_abs;
    logic [63:0]        div_d;
    logic               div_ovf;
    logic [64:0]        trial;
    logic [64:0]        trial_sub;
    logic               trial_ge;
    logic [Q_W-1:0]     quo;
    logic               apb_wr;
    logic               in_take;
    logic               out_free;

    assign apb_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign in_take  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.estimate = out_est_reg;
    assign rsp.variance = out_var_reg;
    assign rsp.fault    = out_fault_reg;

    always_comb
    begin
        case (paddr[4:2])
            kfs_pkg::REG_TRANS:   prdata = trans_reg;
            kfs_pkg::REG_ACTION:  prdata = action_gain_reg;
            kfs_pkg::REG_PROCESS: prdata = {1'b0, process_reg};
            kfs_pkg::REG_SENSOR:  prdata = sensor_reg;
            kfs_pkg::REG_MEAS:    prdata = {1'b0, meas_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        case (step_reg)
            STEP_AX:
            begin
                op_a = trans_reg;
                op_b = est_reg;
            end
            STEP_BU:
            begin
                op_a = action_gain_reg;
                op_b = u_reg;
            end
            STEP_AP:
            begin
                op_a = trans_reg;
                op_b = signed'({1'b0, var_reg});
            end
            STEP_AT:
            begin
                op_a = trans_reg;
                op_b = tmp_reg;
            end
            STEP_HP:
            begin
                op_a = sensor_reg;
                op_b = signed'({1'b0, pp_reg});
            end
            STEP_HG:
            begin
                op_a = sensor_reg;
                op_b = tmp_reg;
            end
            STEP_HX:
            begin
                op_a = sensor_reg;
                op_b = xp_reg;
            end
            STEP_KE:
            begin
                op_a = k_reg;
                op_b = tmp_reg;
            end
            STEP_KH:
            begin
                op_a = k_reg;
                op_b = sensor_reg;
            end
            STEP_MP:
            begin
                op_a = tmp_reg;
                op_b = signed'({1'b0, pp_reg});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // round half up to FRAC_BITS fraction bits
    assign rnd   = (prod_reg + HALF64) >>> FRAC_BITS;
    assign sum_s = rnd + signed'({33'd0, meas_reg});

    always_comb
    begin
        case (step_reg)
            STEP_BU: s32_in = acc_reg + rnd;
            STEP_HX: s32_in = sx64(z_reg) - rnd;
            STEP_KE: s32_in = sx64(xp_reg) + rnd;
            STEP_KH: s32_in = ONE64 - rnd;
            default: s32_in = rnd;
        endcase
        if (step_reg == STEP_AT)
            s31_in = rnd + signed'({33'd0, process_reg});
        else
            s31_in = rnd;
    end

    assign s32_res = sat32_f(s32_in);
    assign s31_res = sat31_f(s31_in);

    // divider setup: |g << FRAC_BITS| + s/2 over s, quotient kept to Q_W bits
    assign num     = sx64(tmp_reg) <<< FRAC_BITS;
    assign num_abs = num[63] ? 64'(-num) : 64'(num);
    assign div_d   = num_abs + (64'(acc_reg) >> 1);
    assign div_ovf = {Q_W'(0), div_d[63:Q_W]} >= 64'(acc_reg);

    assign trial     = {rem_reg, dq_reg[63]};
    assign trial_ge  = trial >= {1'b0, 64'(acc_reg)};
    assign trial_sub = trial - {1'b0, 64'(acc_reg)};
    assign quo       = dq_reg[Q_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= STEP_AX;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            trans_reg       <= signed'(ONE_CFG);
            action_gain_reg <= signed'(ONE_CFG);
            process_reg     <= ONE_CFG[30:0];
            sensor_reg      <= signed'(ONE_CFG);
            meas_reg        <= ONE_CFG[30:0];
            est_reg         <= '0;
            var_reg         <= ONE_CFG[30:0];
        end
        else
        begin
            if (apb_wr)
            begin
                case (paddr[4:2])
                    kfs_pkg::REG_TRANS:   trans_reg       <= signed'(pwdata);
                    kfs_pkg::REG_ACTION:  action_gain_reg <= signed'(pwdata);
                    kfs_pkg::REG_PROCESS: process_reg     <= pwdata[30:0];
                    kfs_pkg::REG_SENSOR:  sensor_reg      <= signed'(pwdata);
                    kfs_pkg::REG_MEAS:    meas_reg        <= pwdata[30:0];
                    default:              ;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        step_reg  <= STEP_AX;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (step_reg == STEP_HG)
                    begin
                        if (sum_s <= 64'sd0)
                        begin
                            step_reg  <= STEP_HX;
                            state_reg <= ST_MUL;
                        end
                        else
                            state_reg <= ST_DIVI;
                    end
                    else if (step_reg == STEP_MP)
                        state_reg <= ST_DONE;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIVI:
                begin
                    cnt_reg <= DIV_STEPS;
                    if (div_ovf)
                        state_reg <= ST_DIVF;
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_reg <= ST_DIVF;
                end
                ST_DIVF:
                begin
                    step_reg  <= STEP_HX;
                    state_reg <= ST_MUL;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        est_reg       <= xp_reg;
                        var_reg       <= pp_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    u_reg     <= req.action;
                    z_reg     <= req.measurement;
                    fault_reg <= 1'b0;
                end
            end
            ST_MUL:
            begin
                prod_reg <= op_a * op_b;
            end
            ST_ACC:
            begin
                case (step_reg)
                    STEP_AX:
                    begin
                        acc_reg <= rnd;
                    end
                    STEP_BU:
                    begin
                        xp_reg <= signed'(s32_res[31:0]);
                        if (s32_res[32])
                            fault_reg <= 1'b1;
                    end
                    STEP_AP:
                    begin
                        tmp_reg <= signed'(s32_res[31:0]);
                        tf_reg  <= s32_res[32];
                    end
                    STEP_AT:
                    begin
                        // a clamped a*P forces the predicted variance to full scale
                        if (tf_reg)
                        begin
                            pp_reg    <= 31'h7fff_ffff;
                            fault_reg <= 1'b1;
                        end
                        else
                        begin
                            pp_reg <= s31_res[30:0];
                            if (s31_res[31])
                                fault_reg <= 1'b1;
                        end
                    end
                    STEP_HG:
                    begin
                        acc_reg <= sum_s;
                        if (sum_s <= 64'sd0)
                        begin
                            k_reg     <= '0;
                            fault_reg <= 1'b1;
                        end
                    end
                    STEP_MP:
                    begin
                        pp_reg <= s31_res[30:0];
                        if (s31_res[31])
                            fault_reg <= 1'b1;
                    end
                    STEP_KE:
                    begin
                        xp_reg <= signed'(s32_res[31:0]);
                        if (s32_res[32])
                            fault_reg <= 1'b1;
                    end
                    default:
                    begin
                        tmp_reg <= signed'(s32_res[31:0]);
                        if (s32_res[32])
                            fault_reg <= 1'b1;
                    end
                endcase
            end
            ST_DIVI:
            begin
                ovf_reg <= div_ovf;
                rem_reg <= {Q_W'(0), div_d[63:Q_W]};
                dq_reg  <= {div_d[Q_W-1:0], (64 - Q_W)'(0)};
            end
            ST_DIV:
            begin
                rem_reg <= trial_ge ? trial_sub[63:0] : trial[63:0];
                dq_reg  <= {dq_reg[62:0], trial_ge};
            end
            ST_DIVF:
            begin
                // gain sign follows g; magnitude clamps into the signed range
                if (!tmp_reg[31])
                begin
                    if (ovf_reg || quo >= Q_HALF)
                    begin
                        k_reg     <= 32'sh7fff_ffff;
                        fault_reg <= 1'b1;
                    end
                    else
                        k_reg <= signed'(quo[31:0]);
                end
                else
                begin
                    if (ovf_reg || quo > Q_HALF)
                    begin
                        k_reg     <= 32'sh8000_0000;
                        fault_reg <= 1'b1;
                    end
                    else
                        k_reg <= signed'(32'(-quo));
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_est_reg   <= xp_reg;
                    out_var_reg   <= pp_reg;
                    out_fault_reg <= fault_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== sim/tb.sv =====
module tb;

    localparam int     FRAC        = 16;
    localparam longint ONE         = 64'sd1 << FRAC;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint S32_MIN     = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 600000;

    typedef struct packed {
        kfs_pkg::sdata_t estimate;
        kfs_pkg::var_t   variance;
        logic            fault;
    } kf_out_t;

    logic           clk;
    logic           rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    kfs_pkg::addr_t paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    kfs_req_if req_ch ();
    kfs_rsp_if rsp_ch ();

    scalar_kalman_filter_step_top #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // filter configuration and state as the block should hold them
    kfs_pkg::sdata_t gain_a;
    kfs_pkg::sdata_t gain_b;
    kfs_pkg::var_t   proc_var_cfg;
    kfs_pkg::sdata_t gain_h;
    kfs_pkg::var_t   meas_var_cfg;
    kfs_pkg::sdata_t est_state;
    kfs_pkg::var_t   var_state;

    kf_out_t pending_estimates[$];

    int  n_cycles     = 0;
    int  n_requests   = 0;
    int  n_responses  = 0;
    int  n_faults     = 0;
    int  n_reg_writes = 0;
    int  n_errors     = 0;
    bit  req_no_gap   = 1'b0;
    bit  rsp_no_stall = 1'b0;
    int  rsp_hold     = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint fx_mul(longint x, longint y);
        return (x * y + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < S32_MIN)
            return S32_MIN;
        return v;
    endfunction

    function automatic longint clamp31(longint v);
        if (v > S32_MAX)
            return S32_MAX;
        if (v < 0)
            return 0;
        return v;
    endfunction

    function automatic kf_out_t kalman_update(kfs_pkg::sdata_t u, kfs_pkg::sdata_t z);
        longint          a, b, h, raw, xp, t, pp, g, s, k, e, x, m, p, n;
        longint unsigned un, us, uq;
        bit              flt;
        kf_out_t         res;
        a   = gain_a;
        b   = gain_b;
        h   = gain_h;
        flt = 1'b0;

        // predict
        raw = fx_mul(a, est_state) + fx_mul(b, u);
        xp  = clamp32(raw);
        if (xp != raw)
            flt = 1'b1;
        raw = fx_mul(a, var_state);
        t   = clamp32(raw);
        if (t != raw)
        begin
            flt = 1'b1;
            pp  = S32_MAX;
        end
        else
        begin
            raw = fx_mul(a, t) + proc_var_cfg;
            pp  = clamp31(raw);
            if (pp != raw)
                flt = 1'b1;
        end

        // gain
        raw = fx_mul(h, pp);
        g   = clamp32(raw);
        if (g != raw)
            flt = 1'b1;
        s = fx_mul(h, g) + meas_var_cfg;
        if (s <= 0)
        begin
            flt = 1'b1;
            k   = 0;
        end
        else
        begin
            n  = g * ONE;
            un = (n < 0) ? -n : n;
            us = s;
            uq = (un + us / 2) / us;
            if (uq > 64'd4294967296)
                uq = 64'd4294967296;
            raw = (n < 0) ? -$signed(uq) : $signed(uq);
            k   = clamp32(raw);
            if (k != raw)
                flt = 1'b1;
        end

        // correct
        raw = z - fx_mul(h, xp);
        e   = clamp32(raw);
        if (e != raw)
            flt = 1'b1;
        raw = xp + fx_mul(k, e);
        x   = clamp32(raw);
        if (x != raw)
            flt = 1'b1;
        raw = ONE - fx_mul(k, h);
        m   = clamp32(raw);
        if (m != raw)
            flt = 1'b1;
        raw = fx_mul(m, pp);
        p   = clamp31(raw);
        if (p != raw)
            flt = 1'b1;

        est_state    = x[31:0];
        var_state    = p[30:0];
        res.estimate = x[31:0];
        res.variance = p[30:0];
        res.fault    = flt;
        return res;
    endfunction

    function automatic logic [31:0] pick_gain(int span);
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'(ONE);
            4: return $urandom();
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    function automatic logic [31:0] pick_var();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return ($urandom() & 32'h8000_0000) | $urandom_range(0, 4 * 65536);
        endcase
    endfunction

    function automatic kfs_pkg::sdata_t pick_sample();
        case ($urandom_range(0, 15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $urandom_range(0, 1 << 22) - (1 << 21);
        endcase
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic check_response(kfs_pkg::sdata_t est, kfs_pkg::var_t vr, logic flt);
        kf_out_t want;
        n_responses++;
        if (pending_estimates.size() == 0)
        begin
            n_errors++;
            $display("%0t response with none expected: expected nothing, got %h %h %b",
                     $time, est, vr, flt);
        end
        else
        begin
            want = pending_estimates.pop_front();
            report_field("estimate", want.estimate, est);
            report_field("variance", {1'b0, want.variance}, {1'b0, vr});
            report_field("fault", {31'b0, want.fault}, {31'b0, flt});
        end
    endtask

    // response sink
    initial
    begin : rsp_sink
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rsp_no_stall ? 0 : $urandom_range(0, 8);
            if (rsp_hold > 0)
            begin
                stall    = rsp_hold;
                rsp_hold = 0;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            check_response(rsp_ch.estimate, rsp_ch.variance, rsp_ch.fault);
        end
    end

    task automatic send_request(kfs_pkg::sdata_t u, kfs_pkg::sdata_t z);
        int gap;
        gap = req_no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= u;
        req_ch.measurement <= z;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_estimates.push_back(kalman_update(u, z));
        n_requests++;
        if (pending_estimates[$].fault)
            n_faults++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(kfs_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_reg_writes++;
        case (idx)
            kfs_pkg::REG_TRANS:   gain_a       = val;
            kfs_pkg::REG_ACTION:  gain_b       = val;
            kfs_pkg::REG_PROCESS: proc_var_cfg = val[30:0];
            kfs_pkg::REG_SENSOR:  gain_h       = val;
            kfs_pkg::REG_MEAS:    meas_var_cfg = val[30:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] a, logic [31:0] b, logic [31:0] q,
                             logic [31:0] h, logic [31:0] r);
        wait_drained();
        reg_write(kfs_pkg::REG_TRANS, a);
        reg_write(kfs_pkg::REG_ACTION, b);
        reg_write(kfs_pkg::REG_PROCESS, q);
        reg_write(kfs_pkg::REG_SENSOR, h);
        reg_write(kfs_pkg::REG_MEAS, r);
    endtask

    task automatic test_reset_state();
        send_request(32'sh0, 32'sh0);
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_request(32'sh8000_0000, 32'sh8000_0000);
    endtask

    task automatic test_field_extremes();
        write_all(32'(ONE), 32'h0000_8000, 32'h0000_4000, 32'(ONE), 32'h0002_0000);
        send_request(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_request(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_request(-32'sd1, 32'sd1);
        send_request(32'sd1, -32'sd1);
        send_request(32'sh5555_5555, 32'shAAAA_AAAA);
        send_request(32'shAAAA_AAAA, 32'sh5555_5555);
    endtask

    task automatic test_saturation();
        // large transition gain drives the variance into the clamp, then a*P clamps too
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'(ONE), 32'(ONE));
        send_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_request(32'sh8000_0000, 32'sh8000_0000);
        send_request(32'sh0010_0000, 32'shFFF0_0000);
    endtask

    task automatic test_zero_denominator();
        write_all(32'(ONE), 32'(ONE), 32'(ONE), 32'h0, 32'h0);
        send_request(32'sh0003_0000, 32'sh0001_0000);
        send_request(32'shFFFE_0000, 32'sh7FFF_FFFF);
    endtask

    task automatic test_negative_variance();
        // no measurement noise: a gain rounded up pushes (1 - K*h) below zero
        write_all(32'h0000_F000, 32'(ONE), 32'h0000_0123, 32'h0003_B7A5, 32'h0);
        send_request(32'sh0002_0000, 32'sh0007_1234);
        send_request(32'shFFFF_8000, 32'sh0001_0000);
        send_request(32'sh0000_0001, 32'shFFFF_FFFF);
    endtask

    task automatic test_output_backpressure();
        write_all(32'(ONE), 32'(ONE), 32'(ONE), 32'(ONE), 32'(ONE));
        req_no_gap = 1'b1;
        rsp_hold   = 400;
        repeat (10) send_request(pick_sample(), pick_sample());
        req_no_gap = 1'b0;
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (2)
        begin
            repeat (6) send_request(pick_sample(), pick_sample());
            wait_drained();
        end
    endtask

    task automatic test_random_settings(int n_phases, int per_phase);
        for (int ph = 0; ph < n_phases; ph++)
        begin
            case (ph)
                0: write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             32'h7FFF_FFFF, 32'hFFFF_FFFF);
                1: write_all(32'h8000_0000, 32'h8000_0000, 32'h0,
                             32'h8000_0000, 32'h0);
                2: write_all(32'(ONE), 32'(ONE), 32'(ONE), 32'(ONE), 32'(ONE));
                default: write_all(pick_gain(80000), pick_gain(140000), pick_var(),
                                   pick_gain(200000), pick_var());
            endcase
            req_no_gap   = ($urandom_range(0, 3) == 0);
            rsp_no_stall = ($urandom_range(0, 3) == 0);
            repeat (per_phase) send_request(pick_sample(), pick_sample());
        end
        wait_drained();
        req_no_gap   = 1'b0;
        rsp_no_stall = 1'b0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = '0;
        req_ch.measurement = '0;
        gain_a             = 32'(ONE);
        gain_b             = 32'(ONE);
        proc_var_cfg       = kfs_pkg::var_t'(ONE);
        gain_h             = 32'(ONE);
        meas_var_cfg       = kfs_pkg::var_t'(ONE);
        est_state          = '0;
        var_state          = kfs_pkg::var_t'(ONE);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_saturation();
        test_zero_denominator();
        test_negative_variance();
        test_output_backpressure();
        test_sender_pause();
        test_random_settings(12, 92);

        wait_drained();
        repeat (150) @(posedge clk);
        if (pending_estimates.size() != 0)
        begin
            n_errors++;
            $display("%0t %0d responses never arrived: expected 0 left, got %0d",
                     $time, pending_estimates.size(), pending_estimates.size());
        end
        $display("filter steps: %0d requests, %0d responses, %0d with fault flagged",
                 n_requests, n_responses, n_faults);
        $display("register writes: %0d, mismatches: %0d", n_reg_writes, n_errors);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/kfs_pkg.sv
hdl/kfs_req_if.sv
hdl/kfs_rsp_if.sv
hdl/scalar_kalman_filter_step_top.sv
sim/tb.sv
